// File: rtl/backlight_duty_mapper_assert.svh
// Assertion macros shared by the block. Both expect clk and rst_n in scope.
`ifndef BACKLIGHT_DUTY_MAPPER_ASSERT_SVH
`define BACKLIGHT_DUTY_MAPPER_ASSERT_SVH

`define BDM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("backlight_duty_mapper: same-cycle check failed");

`define BDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("backlight_duty_mapper: next-cycle check failed");

`endif

// File: rtl/bdm_pkg.sv
`default_nettype none

package bdm_pkg;

  localparam int BR_W     = 10;
  localparam int DUTY_W   = 24;
  localparam int REG_W    = 8;
  localparam int PROD_W   = 34;
  localparam int BAND_W   = 27;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [DUTY_W-1:0] DEADBAND_NUM = 24'd10000000;
  localparam logic [2:0]        DEADBAND_MUL = 3'd5;
  localparam logic [REG_W-1:0]  REG_CLEAR    = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_SWITCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUTY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUTY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL,
    S_MAP_GO,
    S_MAP_WAIT,
    S_BAND_GO,
    S_BAND_WAIT,
    S_CMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              power_up;
    logic              power_down;
    logic              pwm_write;
    logic              pwm_on;
    logic [DUTY_W-1:0] duty_ns;
    logic              reg_write;
    logic [REG_W-1:0]  reg_value;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DUTY_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/bdm_in_if.sv
`default_nettype none

interface bdm_in_if;
  logic                     valid;
  logic                     ready;
  logic [bdm_pkg::BR_W-1:0] brightness;
  logic                     blanked;

  modport source (output valid, output brightness, output blanked, input ready);
  modport sink   (input valid, input brightness, input blanked, output ready);
endinterface

`default_nettype wire

// File: rtl/bdm_out_if.sv
`default_nettype none

interface bdm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       power_up;
  logic                       power_down;
  logic                       pwm_write;
  logic                       pwm_on;
  logic [bdm_pkg::DUTY_W-1:0] duty_ns;
  logic                       reg_write;
  logic [bdm_pkg::REG_W-1:0]  reg_value;

  modport source (output valid, output power_up, output power_down, output pwm_write,
                  output pwm_on, output duty_ns, output reg_write, output reg_value,
                  input ready);
  modport sink   (input valid, input power_up, input power_down, input pwm_write,
                  input pwm_on, input duty_ns, input reg_write, input reg_value,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/bdm_cfg_if.sv
`default_nettype none

interface bdm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bdm_pkg::CFG_IDX_W-1:0] index;
  logic [bdm_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bdm_div.sv
`default_nettype none

module bdm_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bdm_pkg::div_req_t req,
  output bdm_pkg::div_rsp_t      rsp
);

  localparam int NUM_W = bdm_pkg::PROD_W;
  localparam int DEN_W = bdm_pkg::DUTY_W;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/backlight_duty_mapper.sv
// Channel   Modport  Carries
// in_ch     sink     brightness, blanked
// out_ch    source   power_up, power_down, pwm_write, pwm_on, duty_ns,
//                    reg_write, reg_value
// cfg_ch    sink     index, data (always ready)
//
// A mapped duty is set by two passes of one shared restoring divider (34 steps each); equal or
// crossed limits skip one. Register mode, zero brightness and ignored requests go from
// S_DECIDE straight to S_FINISH and do not use the divider.
// Synchronous active-low reset restores the register defaults and marks the supply on.
// A finished result waits in the output register; the next request is taken meanwhile,
// but its result is held back until the previous transfer completes.

`default_nettype none

module backlight_duty_mapper (
  input wire logic   clk,
  input wire logic   rst_n,
  bdm_in_if.sink     in_ch,
  bdm_out_if.source  out_ch,
  bdm_cfg_if.sink    cfg_ch
);

  localparam int BR_W   = bdm_pkg::BR_W;
  localparam int DUTY_W = bdm_pkg::DUTY_W;
  localparam int PROD_W = bdm_pkg::PROD_W;
  localparam int BAND_W = bdm_pkg::BAND_W;

  logic              pwm_mode_r;
  logic              has_switch_r;
  logic [BR_W-1:0]   max_br_r;
  logic [BR_W-1:0]   min_br_r;
  logic [DUTY_W-1:0] low_duty_r;
  logic [DUTY_W-1:0] high_duty_r;
  logic [DUTY_W-1:0] period_r;

  bdm_pkg::state_t   state_r, state_nxt;
  logic              powered_r, powered_nxt;
  logic [DUTY_W-1:0] last_duty_r, last_duty_nxt;
  logic [BR_W-1:0]   br_r, br_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              neg_r, neg_nxt;
  logic [DUTY_W-1:0] mapped_r, mapped_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  bdm_pkg::result_t  res_r, res_nxt;
  bdm_pkg::result_t  out_r;
  logic              out_valid_r, out_valid_nxt;

  bdm_pkg::div_req_t div_req;
  bdm_pkg::div_rsp_t div_rsp;

  logic              in_ready;
  logic              in_fire;
  logic              out_load;
  logic              skip;
  logic              zero_req;
  logic              den_zero;
  logic              den_neg;
  logic [BR_W-1:0]   br_clamp;
  logic [BR_W-1:0]   br_raise;
  logic [BR_W-1:0]   br_off;
  logic [BR_W-1:0]   den;
  logic [DUTY_W-1:0] duty_span;
  logic [DUTY_W-1:0] quo_lo;
  logic [DUTY_W-1:0] duty_diff;
  logic              in_div_wait;
  logic              st_finish;
  logic              st_decide;

  assign in_fire = in_ch.valid && in_ready;
  assign zero_req = (br_r == '0);
  assign skip = has_switch_r && !powered_r && zero_req;
  assign den_zero = (max_br_r == min_br_r);
  assign den_neg = (min_br_r > max_br_r);
  assign den = max_br_r - min_br_r;
  assign quo_lo = div_rsp.quotient[DUTY_W-1:0];
  assign in_div_wait = (state_r == bdm_pkg::S_MAP_WAIT) || (state_r == bdm_pkg::S_BAND_WAIT);
  assign st_finish = (state_r == bdm_pkg::S_FINISH);
  assign st_decide = (state_r == bdm_pkg::S_DECIDE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_mode_r   <= 1'b1;
      has_switch_r <= 1'b0;
      max_br_r     <= BR_W'(255);
      min_br_r     <= '0;
      low_duty_r   <= '0;
      high_duty_r  <= '1;
      period_r     <= '1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bdm_pkg::CFG_PWM_MODE:   pwm_mode_r   <= cfg_ch.data[0];
        bdm_pkg::CFG_HAS_SWITCH: has_switch_r <= cfg_ch.data[0];
        bdm_pkg::CFG_MAX_BR:     max_br_r     <= cfg_ch.data[BR_W-1:0];
        bdm_pkg::CFG_MIN_BR:     min_br_r     <= cfg_ch.data[BR_W-1:0];
        bdm_pkg::CFG_LOW_DUTY:   low_duty_r   <= cfg_ch.data[DUTY_W-1:0];
        bdm_pkg::CFG_HIGH_DUTY:  high_duty_r  <= cfg_ch.data[DUTY_W-1:0];
        bdm_pkg::CFG_PERIOD:     period_r     <= cfg_ch.data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdm_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = bdm_pkg::S_DECIDE;
        end
      end
      bdm_pkg::S_DECIDE: begin
        if (skip || !pwm_mode_r || zero_req) begin
          state_nxt = bdm_pkg::S_FINISH;
        end else begin
          state_nxt = bdm_pkg::S_MUL;
        end
      end
      bdm_pkg::S_MUL: begin
        if (den_zero || den_neg) begin
          state_nxt = bdm_pkg::S_BAND_GO;
        end else begin
          state_nxt = bdm_pkg::S_MAP_GO;
        end
      end
      bdm_pkg::S_MAP_GO:    state_nxt = bdm_pkg::S_MAP_WAIT;
      bdm_pkg::S_MAP_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = bdm_pkg::S_BAND_GO;
        end
      end
      bdm_pkg::S_BAND_GO:   state_nxt = bdm_pkg::S_BAND_WAIT;
      bdm_pkg::S_BAND_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = bdm_pkg::S_CMP;
        end
      end
      bdm_pkg::S_CMP:       state_nxt = bdm_pkg::S_FINISH;
      bdm_pkg::S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = bdm_pkg::S_IDLE;
        end
      end
      default:              state_nxt = bdm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = DUTY_W'(den);
    case (state_r)
      bdm_pkg::S_IDLE:    in_ready = 1'b1;
      bdm_pkg::S_MAP_GO:  div_req.start = 1'b1;
      bdm_pkg::S_BAND_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = PROD_W'(bdm_pkg::DEADBAND_NUM);
        div_req.divisor  = (period_r == '0) ? DUTY_W'(1) : period_r;
      end
      bdm_pkg::S_FINISH:  out_load = !out_valid_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  always_comb begin
    br_clamp  = (in_ch.brightness > max_br_r) ? max_br_r : in_ch.brightness;
    br_raise  = (br_r < min_br_r) ? min_br_r : br_r;
    br_off    = br_raise - min_br_r;
    duty_span = (high_duty_r >= low_duty_r) ? (high_duty_r - low_duty_r)
                                            : (low_duty_r - high_duty_r);
    duty_diff = (mapped_r >= last_duty_r) ? (mapped_r - last_duty_r)
                                          : (last_duty_r - mapped_r);

    br_nxt        = br_r;
    powered_nxt   = powered_r;
    last_duty_nxt = last_duty_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    mapped_nxt    = mapped_r;
    band_nxt      = band_r;
    res_nxt       = res_r;

    case (state_r)
      bdm_pkg::S_IDLE: begin
        if (in_fire) begin
          br_nxt = in_ch.blanked ? '0 : br_clamp;
          if (in_ch.blanked) begin
            last_duty_nxt = '0;
          end
        end
      end
      bdm_pkg::S_DECIDE: begin
        res_nxt = '0;
        res_nxt.reg_value = bdm_pkg::REG_CLEAR;
        if (!skip) begin
          res_nxt.power_up   = has_switch_r && !powered_r;
          res_nxt.power_down = has_switch_r && zero_req;
          if (has_switch_r && !powered_r) begin
            powered_nxt = 1'b1;
          end
          if (has_switch_r && zero_req) begin
            powered_nxt = 1'b0;
          end
          if (!pwm_mode_r) begin
            res_nxt.reg_write = 1'b1;
            res_nxt.reg_value = br_r[bdm_pkg::REG_W-1:0];
          end else if (zero_req) begin
            res_nxt.pwm_write = 1'b1;
          end
        end
      end
      bdm_pkg::S_MUL: begin
        prod_nxt   = PROD_W'(br_off) * PROD_W'(duty_span);
        neg_nxt    = low_duty_r > high_duty_r;
        mapped_nxt = den_zero ? high_duty_r : low_duty_r;
      end
      bdm_pkg::S_MAP_WAIT: begin
        if (div_rsp.done) begin
          mapped_nxt = neg_r ? (low_duty_r - quo_lo) : (low_duty_r + quo_lo);
        end
      end
      bdm_pkg::S_BAND_WAIT: begin
        if (div_rsp.done) begin
          band_nxt = BAND_W'(quo_lo) * BAND_W'(bdm_pkg::DEADBAND_MUL);
        end
      end
      bdm_pkg::S_CMP: begin
        if (BAND_W'(duty_diff) > band_r) begin
          last_duty_nxt     = mapped_r;
          res_nxt.pwm_write = 1'b1;
          res_nxt.pwm_on    = 1'b1;
          res_nxt.duty_ns   = mapped_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdm_pkg::S_IDLE;
      powered_r   <= 1'b1;
      last_duty_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      powered_r   <= powered_nxt;
      last_duty_r <= last_duty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    br_r     <= br_nxt;
    prod_r   <= prod_nxt;
    neg_r    <= neg_nxt;
    mapped_r <= mapped_nxt;
    band_r   <= band_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  bdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.power_up   = out_r.power_up;
  assign out_ch.power_down = out_r.power_down;
  assign out_ch.pwm_write  = out_r.pwm_write;
  assign out_ch.pwm_on     = out_r.pwm_on;
  assign out_ch.duty_ns    = out_r.duty_ns;
  assign out_ch.reg_write  = out_r.reg_write;
  assign out_ch.reg_value  = out_r.reg_value;

`include "backlight_duty_mapper_assert.svh"

  `BDM_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, in_div_wait)
  `BDM_ASSERT_NOW(a_reg_write_mode, st_finish && res_r.reg_write, !pwm_mode_r && !res_r.pwm_write)
  `BDM_ASSERT_NOW(a_enable_tracks_last, st_finish && res_r.pwm_on, res_r.duty_ns == last_duty_r)
  `BDM_ASSERT_NEXT(a_skip_keeps_power, st_decide && skip, powered_r == $past(powered_r))

endmodule

`default_nettype wire
